// ----- hw/rtl/stt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared types, character constants and character class helpers.
// ----------------------------------------------------------------------------
package stt_pkg;

    // Lexer modes.
    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_WORD  = 4'd1,
        M_DOT   = 4'd2,
        M_SLASH = 4'd3,
        M_LINE  = 4'd4,
        M_BLOCK = 4'd5,
        M_STAR  = 4'd6,
        M_STR   = 4'd7,
        M_ESC   = 4'd8,
        M_HEX1  = 4'd9,
        M_HEX2  = 4'd10
    } lex_mode_t;

    // Token kinds.
    typedef enum logic [1:0] {
        K_IDENT  = 2'd0,
        K_NUM    = 2'd1,
        K_STRING = 2'd2,
        K_SYMBOL = 2'd3
    } tok_kind_t;

    // Error codes.
    typedef enum logic [1:0] {
        E_NONE    = 2'd0,
        E_ESCAPE  = 2'd1,
        E_HEX     = 2'd2,
        E_SPARE   = 2'd3
    } err_code_t;

    // Where a result takes its start position from.
    typedef enum logic [1:0] {
        POS_TOKEN = 2'd0,
        POS_HELD  = 2'd1,
        POS_CUR   = 2'd2,
        POS_NONE  = 2'd3
    } pos_src_t;

    // Lexer control state.
    typedef struct packed {
        lex_mode_t  mode;
        tok_kind_t  kind;
        logic       dot_seen;
        logic [3:0] hex_hi;
    } lex_ctl_t;

    // One result beat, without its position.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] token_byte;
        tok_kind_t  kind;
        logic       begins;
        logic       ends;
        err_code_t  err;
        pos_src_t   src;
    } res_info_t;

    localparam int MAX_RES = 4;

    // Character constants.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_lower_af(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h66);
    endfunction

    function automatic logic is_upper_af(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h46);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || is_lower_af(c) || is_upper_af(c);
    endfunction

    // Nibble value of a hex digit; meaningless for other bytes.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (is_digit(c)) begin
            v = c - 8'h30;
        end
        else if (is_lower_af(c)) begin
            v = c - 8'h57;
        end
        else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic res_info_t mk_res(input logic has, input logic [7:0] b,
                                         input tok_kind_t k, input logic beg,
                                         input logic fin, input err_code_t e,
                                         input pos_src_t s);
        res_info_t r;
        r.has_byte   = has;
        r.token_byte = b;
        r.kind       = k;
        r.begins     = beg;
        r.ends       = fin;
        r.err        = e;
        r.src        = s;
        return r;
    endfunction

endpackage

// ----- hw/rtl/stt_lex_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer lexing logic
// Decides, for one source byte, the result beats it causes and the next
// lexer state, line and column counters and saved token positions.
// ----------------------------------------------------------------------------
module stt_lex_core #(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16
) (
    input  logic [7:0]              char_byte,
    input  logic                    eos,
    input  stt_pkg::lex_ctl_t       ctl,
    input  logic [LINE_BITS-1:0]    line_cnt,
    input  logic [COLUMN_BITS-1:0]  col_cnt,
    input  logic [LINE_BITS-1:0]    tok_line,
    input  logic [COLUMN_BITS-1:0]  tok_col,
    input  logic [LINE_BITS-1:0]    held_line,
    input  logic [COLUMN_BITS-1:0]  held_col,
    output stt_pkg::lex_ctl_t       ctl_next,
    output logic [LINE_BITS-1:0]    line_next,
    output logic [COLUMN_BITS-1:0]  col_next,
    output logic [LINE_BITS-1:0]    tok_line_next,
    output logic [COLUMN_BITS-1:0]  tok_col_next,
    output logic [LINE_BITS-1:0]    held_line_next,
    output logic [COLUMN_BITS-1:0]  held_col_next,
    output stt_pkg::res_info_t      res [stt_pkg::MAX_RES],
    output logic [2:0]              res_cnt
);

    stt_pkg::lex_mode_t mode;
    stt_pkg::tok_kind_t kind;
    logic               dot;
    logic [3:0]         hex_hi;
    logic               tok_new;
    logic               held_new;
    logic               again;
    logic [2:0]         n;
    stt_pkg::pos_src_t  tsrc;
    stt_pkg::pos_src_t  hsrc;

    // Position counters: saturating column, line feed opens a new line.
    always_comb
    begin
        if (eos) begin
            line_next = '0;
            col_next  = '0;
        end
        else if (char_byte == stt_pkg::CH_LF) begin
            line_next = (line_cnt == '1) ? line_cnt : line_cnt + LINE_BITS'(1);
            col_next  = '0;
        end
        else begin
            line_next = line_cnt;
            col_next  = (col_cnt == '1) ? col_cnt : col_cnt + COLUMN_BITS'(1);
        end
    end

    // Lexing: the current mode, one re-lex from idle if the byte closed a
    // token, then the end-of-source flush.
    always_comb
    begin
        mode     = ctl.mode;
        kind     = ctl.kind;
        dot      = ctl.dot_seen;
        hex_hi   = ctl.hex_hi;
        tok_new  = 1'b0;
        held_new = 1'b0;
        again    = 1'b1;
        n        = 3'd0;
        tsrc     = stt_pkg::POS_TOKEN;
        hsrc     = stt_pkg::POS_HELD;
        for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
            res[i] = '0;
        end

        for (int p = 0; p < 2; p++) begin
            if (again) begin
                again = 1'b0;
                tsrc  = tok_new ? stt_pkg::POS_CUR : stt_pkg::POS_TOKEN;
                case (mode)
                    stt_pkg::M_WORD:
                    begin
                        if (stt_pkg::is_word(char_byte)) begin
                            if (kind == stt_pkg::K_IDENT || char_byte != stt_pkg::CH_UNDER) begin
                                res[n[1:0]] = stt_pkg::mk_res(1'b1, char_byte, kind, 1'b0,
                                    1'b0, stt_pkg::E_NONE, tsrc);
                                n = n + 3'd1;
                            end
                        end
                        else if (char_byte == stt_pkg::CH_DOT && kind == stt_pkg::K_NUM
                                 && !dot) begin
                            if (eos) begin
                                dot = 1'b1;
                                res[n[1:0]] = stt_pkg::mk_res(1'b1, stt_pkg::CH_DOT, kind,
                                    1'b0, 1'b0, stt_pkg::E_NONE, tsrc);
                                n = n + 3'd1;
                            end
                            else begin
                                held_new = 1'b1;
                                mode     = stt_pkg::M_DOT;
                            end
                        end
                        else begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b0, 8'h00, kind, 1'b0, 1'b1,
                                stt_pkg::E_NONE, tsrc);
                            n     = n + 3'd1;
                            mode  = stt_pkg::M_IDLE;
                            again = 1'b1;
                        end
                    end
                    stt_pkg::M_DOT:
                    begin
                        if (stt_pkg::is_digit(char_byte)) begin
                            dot = 1'b1;
                            res[n[1:0]] = stt_pkg::mk_res(1'b1, stt_pkg::CH_DOT, kind, 1'b0,
                                1'b0, stt_pkg::E_NONE, tsrc);
                            n = n + 3'd1;
                            res[n[1:0]] = stt_pkg::mk_res(1'b1, char_byte, kind, 1'b0,
                                1'b0, stt_pkg::E_NONE, tsrc);
                            n    = n + 3'd1;
                            mode = stt_pkg::M_WORD;
                        end
                        else begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b0, 8'h00, kind, 1'b0, 1'b1,
                                stt_pkg::E_NONE, tsrc);
                            n = n + 3'd1;
                            res[n[1:0]] = stt_pkg::mk_res(1'b1, stt_pkg::CH_DOT,
                                stt_pkg::K_SYMBOL, 1'b1, 1'b1, stt_pkg::E_NONE, hsrc);
                            n     = n + 3'd1;
                            mode  = stt_pkg::M_IDLE;
                            again = 1'b1;
                        end
                    end
                    stt_pkg::M_SLASH:
                    begin
                        if (char_byte == stt_pkg::CH_SLASH) begin
                            mode = stt_pkg::M_LINE;
                        end
                        else if (char_byte == stt_pkg::CH_STAR) begin
                            mode = stt_pkg::M_BLOCK;
                        end
                        else begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b1, stt_pkg::CH_SLASH,
                                stt_pkg::K_SYMBOL, 1'b1, 1'b1, stt_pkg::E_NONE, hsrc);
                            n     = n + 3'd1;
                            mode  = stt_pkg::M_IDLE;
                            again = 1'b1;
                        end
                    end
                    stt_pkg::M_LINE:
                    begin
                        if (char_byte == stt_pkg::CH_LF) begin
                            mode = stt_pkg::M_IDLE;
                        end
                    end
                    stt_pkg::M_BLOCK:
                    begin
                        if (char_byte == stt_pkg::CH_STAR) begin
                            mode = stt_pkg::M_STAR;
                        end
                    end
                    stt_pkg::M_STAR:
                    begin
                        if (char_byte == stt_pkg::CH_SLASH) begin
                            mode = stt_pkg::M_IDLE;
                        end
                        else if (char_byte != stt_pkg::CH_STAR) begin
                            mode = stt_pkg::M_BLOCK;
                        end
                    end
                    stt_pkg::M_STR:
                    begin
                        if (char_byte == stt_pkg::CH_QUOTE) begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b0, 8'h00, kind, 1'b0, 1'b1,
                                stt_pkg::E_NONE, tsrc);
                            n    = n + 3'd1;
                            mode = stt_pkg::M_IDLE;
                        end
                        else if (char_byte == stt_pkg::CH_BSLASH) begin
                            mode = stt_pkg::M_ESC;
                        end
                        else begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b1, char_byte, kind, 1'b0, 1'b0,
                                stt_pkg::E_NONE, tsrc);
                            n = n + 3'd1;
                        end
                    end
                    stt_pkg::M_ESC:
                    begin
                        mode = stt_pkg::M_STR;
                        if (char_byte == stt_pkg::CH_QUOTE || char_byte == stt_pkg::CH_BSLASH)
                        begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b1, char_byte, kind, 1'b0, 1'b0,
                                stt_pkg::E_NONE, tsrc);
                            n = n + 3'd1;
                        end
                        else if (char_byte == stt_pkg::CH_LOW_N) begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b1, stt_pkg::CH_LF, kind, 1'b0,
                                1'b0, stt_pkg::E_NONE, tsrc);
                            n = n + 3'd1;
                        end
                        else if (char_byte == stt_pkg::CH_LOW_R) begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b1, stt_pkg::CH_CR, kind, 1'b0,
                                1'b0, stt_pkg::E_NONE, tsrc);
                            n = n + 3'd1;
                        end
                        else if (char_byte == stt_pkg::CH_LOW_T) begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b1, stt_pkg::CH_TAB, kind, 1'b0,
                                1'b0, stt_pkg::E_NONE, tsrc);
                            n = n + 3'd1;
                        end
                        else if (char_byte == stt_pkg::CH_LOW_X) begin
                            mode = stt_pkg::M_HEX1;
                        end
                        else begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b0, 8'h00, kind, 1'b0, 1'b0,
                                stt_pkg::E_ESCAPE, tsrc);
                            n = n + 3'd1;
                        end
                    end
                    stt_pkg::M_HEX1:
                    begin
                        if (!stt_pkg::is_hex(char_byte)) begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b0, 8'h00, kind, 1'b0, 1'b0,
                                stt_pkg::E_HEX, tsrc);
                            n    = n + 3'd1;
                            mode = stt_pkg::M_STR;
                        end
                        else begin
                            hex_hi = stt_pkg::hex_val(char_byte);
                            mode   = stt_pkg::M_HEX2;
                        end
                    end
                    stt_pkg::M_HEX2:
                    begin
                        if (!stt_pkg::is_hex(char_byte)) begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b0, 8'h00, kind, 1'b0, 1'b0,
                                stt_pkg::E_HEX, tsrc);
                        end
                        else begin
                            res[n[1:0]] = stt_pkg::mk_res(1'b1,
                                {hex_hi, stt_pkg::hex_val(char_byte)}, kind, 1'b0, 1'b0,
                                stt_pkg::E_NONE, tsrc);
                        end
                        n    = n + 3'd1;
                        mode = stt_pkg::M_STR;
                    end
                    default:
                    begin
                        // Idle between tokens; unused mode codes land here too.
                        mode = stt_pkg::M_IDLE;
                        if (stt_pkg::is_space(char_byte)) begin
                            mode = stt_pkg::M_IDLE;
                        end
                        else if (char_byte == stt_pkg::CH_SLASH) begin
                            held_new = 1'b1;
                            mode     = stt_pkg::M_SLASH;
                        end
                        else begin
                            tok_new = 1'b1;
                            if (char_byte == stt_pkg::CH_QUOTE) begin
                                kind = stt_pkg::K_STRING;
                                res[n[1:0]] = stt_pkg::mk_res(1'b0, 8'h00, kind, 1'b1, 1'b0,
                                    stt_pkg::E_NONE, stt_pkg::POS_CUR);
                                n    = n + 3'd1;
                                mode = stt_pkg::M_STR;
                            end
                            else if (stt_pkg::is_word(char_byte)) begin
                                kind = stt_pkg::is_digit(char_byte) ? stt_pkg::K_NUM
                                                                    : stt_pkg::K_IDENT;
                                dot  = 1'b0;
                                res[n[1:0]] = stt_pkg::mk_res(1'b1, char_byte, kind, 1'b1,
                                    1'b0, stt_pkg::E_NONE, stt_pkg::POS_CUR);
                                n    = n + 3'd1;
                                mode = stt_pkg::M_WORD;
                            end
                            else begin
                                res[n[1:0]] = stt_pkg::mk_res(1'b1, char_byte,
                                    stt_pkg::K_SYMBOL, 1'b1, 1'b1, stt_pkg::E_NONE,
                                    stt_pkg::POS_CUR);
                                n = n + 3'd1;
                            end
                        end
                    end
                endcase
                hsrc = held_new ? stt_pkg::POS_CUR : stt_pkg::POS_HELD;
            end
        end

        // End of source closes whatever is still open.
        tsrc = tok_new ? stt_pkg::POS_CUR : stt_pkg::POS_TOKEN;
        if (eos) begin
            case (mode)
                stt_pkg::M_WORD, stt_pkg::M_STR:
                begin
                    res[n[1:0]] = stt_pkg::mk_res(1'b0, 8'h00, kind, 1'b0, 1'b1,
                        stt_pkg::E_NONE, tsrc);
                    n = n + 3'd1;
                end
                stt_pkg::M_DOT:
                begin
                    res[n[1:0]] = stt_pkg::mk_res(1'b0, 8'h00, kind, 1'b0, 1'b1,
                        stt_pkg::E_NONE, tsrc);
                    n = n + 3'd1;
                    res[n[1:0]] = stt_pkg::mk_res(1'b1, stt_pkg::CH_DOT, stt_pkg::K_SYMBOL,
                        1'b1, 1'b1, stt_pkg::E_NONE, hsrc);
                    n = n + 3'd1;
                end
                stt_pkg::M_SLASH:
                begin
                    res[n[1:0]] = stt_pkg::mk_res(1'b1, stt_pkg::CH_SLASH, stt_pkg::K_SYMBOL,
                        1'b1, 1'b1, stt_pkg::E_NONE, hsrc);
                    n = n + 3'd1;
                end
                stt_pkg::M_ESC:
                begin
                    res[n[1:0]] = stt_pkg::mk_res(1'b0, 8'h00, kind, 1'b0, 1'b1,
                        stt_pkg::E_ESCAPE, tsrc);
                    n = n + 3'd1;
                end
                stt_pkg::M_HEX1, stt_pkg::M_HEX2:
                begin
                    res[n[1:0]] = stt_pkg::mk_res(1'b0, 8'h00, kind, 1'b0, 1'b1,
                        stt_pkg::E_HEX, tsrc);
                    n = n + 3'd1;
                end
                default:
                begin
                    n = n;
                end
            endcase
        end
        res_cnt = n;
    end

    // Next lexer state and saved positions; end of source returns to reset.
    always_comb
    begin
        if (eos) begin
            ctl_next       = '0;
            tok_line_next  = '0;
            tok_col_next   = '0;
            held_line_next = '0;
            held_col_next  = '0;
        end
        else begin
            ctl_next.mode     = mode;
            ctl_next.kind     = kind;
            ctl_next.dot_seen = dot;
            ctl_next.hex_hi   = hex_hi;
            tok_line_next     = tok_new ? line_cnt : tok_line;
            tok_col_next      = tok_new ? col_cnt : tok_col;
            held_line_next    = held_new ? line_cnt : held_line;
            held_col_next     = held_new ? col_cnt : held_col;
        end
    end

endmodule

// ----- hw/rtl/source_text_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexer for a C-like language: one source byte in, token beats out.
// ----------------------------------------------------------------------------
// The block takes one source byte per clock cycle, unless the output stalls
// or a byte causes more than one beat, and sends each token character as its
// own output beat, tagged with its token kind, begin and end marks and the line
// and column where the token starts. A byte that causes several output beats
// holds the lexer until its last beat is taken into the output register (at
// most four beats, for example a refused dot followed by a one-letter word at
// the end of the source); bytes that cause at most one beat flow at one byte
// per cycle while m_tready stays high. Each byte passes through an input
// register, the lexing logic and an output register. Whitespace and comments
// produce no beats. Asserting tlast on an input beat ends the source: open
// tokens are closed and all state, line and column counters included, returns to reset.
module source_text_tokenizer #(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16,
    localparam int FIELD_W    = 13 + LINE_BITS + COLUMN_BITS,
    localparam int OUT_W      = ((FIELD_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // Input beats. tdata: char_byte. tlast: end_of_source.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // [7:0] char_byte
    input  logic             s_tlast,
    // Output beats. tlast: run_last.
    output logic             m_tvalid,
    input  logic             m_tready,
    // has_byte, token_byte, token_begins, token_ends, start_line, start_column,
    // error_code, then zero fill
    output logic [OUT_W-1:0] m_tdata,
    output logic [1:0]       m_tuser,     // [1:0] token_kind
    output logic             m_tlast
);

    // Input register.
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_eos_reg;

    // Lexer state registers.
    stt_pkg::lex_ctl_t      ctl_reg;
    logic [LINE_BITS-1:0]   line_reg;
    logic [COLUMN_BITS-1:0] col_reg;
    logic [LINE_BITS-1:0]   tok_line_reg;
    logic [COLUMN_BITS-1:0] tok_col_reg;
    logic [LINE_BITS-1:0]   held_line_reg;
    logic [COLUMN_BITS-1:0] held_col_reg;
    logic [1:0]             idx_reg;

    // Output register.
    logic                   out_valid_reg;
    stt_pkg::res_info_t     out_info_reg;
    logic [LINE_BITS-1:0]   out_line_reg;
    logic [COLUMN_BITS-1:0] out_col_reg;
    logic                   out_last_reg;

    // Lexer outputs.
    stt_pkg::lex_ctl_t      ctl_next;
    logic [LINE_BITS-1:0]   line_next;
    logic [COLUMN_BITS-1:0] col_next;
    logic [LINE_BITS-1:0]   tok_line_next;
    logic [COLUMN_BITS-1:0] tok_col_next;
    logic [LINE_BITS-1:0]   held_line_next;
    logic [COLUMN_BITS-1:0] held_col_next;
    stt_pkg::res_info_t     res [stt_pkg::MAX_RES];
    logic [2:0]             res_cnt;

    // Handshake and sequencing.
    stt_pkg::res_info_t     cur_res;
    logic [LINE_BITS-1:0]   cur_line;
    logic [COLUMN_BITS-1:0] cur_col;
    logic                   out_free;
    logic                   is_last;
    logic                   emit_now;
    logic                   step_done;

    stt_lex_core #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_core (
        .char_byte      (in_byte_reg),
        .eos            (in_eos_reg),
        .ctl            (ctl_reg),
        .line_cnt       (line_reg),
        .col_cnt        (col_reg),
        .tok_line       (tok_line_reg),
        .tok_col        (tok_col_reg),
        .held_line      (held_line_reg),
        .held_col       (held_col_reg),
        .ctl_next       (ctl_next),
        .line_next      (line_next),
        .col_next       (col_next),
        .tok_line_next  (tok_line_next),
        .tok_col_next   (tok_col_next),
        .held_line_next (held_line_next),
        .held_col_next  (held_col_next),
        .res            (res),
        .res_cnt        (res_cnt)
    );

    // Pick the pending result beat and its start position.
    always_comb
    begin
        cur_res = res[idx_reg];
        case (cur_res.src)
            stt_pkg::POS_TOKEN:
            begin
                cur_line = tok_line_reg;
                cur_col  = tok_col_reg;
            end
            stt_pkg::POS_HELD:
            begin
                cur_line = held_line_reg;
                cur_col  = held_col_reg;
            end
            stt_pkg::POS_CUR:
            begin
                cur_line = line_reg;
                cur_col  = col_reg;
            end
            default:
            begin
                cur_line = '0;
                cur_col  = '0;
            end
        endcase
    end

    // A byte is retired once its last result beat moves to the output register, or at once if it causes no beats.
    assign out_free  = !out_valid_reg || m_tready;
    assign is_last   = ({1'b0, idx_reg} + 3'd1) == res_cnt;
    assign emit_now  = in_valid_reg && (res_cnt != 3'd0) && out_free;
    assign step_done = in_valid_reg && ((res_cnt == 3'd0) || (out_free && is_last));
    assign s_tready  = !in_valid_reg || step_done;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            ctl_reg       <= '0;
            line_reg      <= '0;
            col_reg       <= '0;
            tok_line_reg  <= '0;
            tok_col_reg   <= '0;
            held_line_reg <= '0;
            held_col_reg  <= '0;
        end
        else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= emit_now;
            end
            if (emit_now) begin
                idx_reg <= step_done ? 2'd0 : idx_reg + 2'd1;
            end
            if (step_done) begin
                ctl_reg       <= ctl_next;
                line_reg      <= line_next;
                col_reg       <= col_next;
                tok_line_reg  <= tok_line_next;
                tok_col_reg   <= tok_col_next;
                held_line_reg <= held_line_next;
                held_col_reg  <= held_col_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
        if (emit_now) begin
            out_info_reg <= cur_res;
            out_line_reg <= cur_line;
            out_col_reg  <= cur_col;
            out_last_reg <= is_last;
        end
    end

    // Output beat packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_info_reg.err, out_col_reg, out_line_reg,
                              out_info_reg.ends, out_info_reg.begins,
                              out_info_reg.token_byte, out_info_reg.has_byte});
    assign m_tuser  = out_info_reg.kind;
    assign m_tlast  = out_last_reg;

endmodule
